FILE: rtl/core/ltc_pkg.sv
// Shared types, character codes and keyword table for the token classifier.
package ltc_pkg;

  localparam int KEPT_CHARS   = 8;
  localparam int HEAD_IDX_W   = $clog2(KEPT_CHARS);
  localparam int HEAD_W       = 8 * KEPT_CHARS;
  localparam int LEN_W        = 6;
  localparam int MAX_WORD_DEF = 50;
  localparam int NUM_KW       = 10;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0a;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2a;
  localparam logic [7:0] CH_PLUS       = 8'h2b;
  localparam logic [7:0] CH_COMMA      = 8'h2c;
  localparam logic [7:0] CH_MINUS      = 8'h2d;
  localparam logic [7:0] CH_SLASH      = 8'h2f;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_COLON      = 8'h3a;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3b;
  localparam logic [7:0] CH_EQUAL      = 8'h3d;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
  localparam logic [7:0] CH_LBRACE     = 8'h7b;
  localparam logic [7:0] CH_RBRACE     = 8'h7d;

  typedef enum logic [2:0] {
    CLS_KEYWORD   = 3'd0,
    CLS_IDENT     = 3'd1,
    CLS_SEPARATOR = 3'd2,
    CLS_OPERATOR  = 3'd3,
    CLS_PREPROC   = 3'd4
  } token_class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    token_class_t      token_class;
    logic [LEN_W-1:0]  token_length;
    logic [HEAD_W-1:0] token_head;
    logic [7:0]        single_char;
    logic              last_of_run;
  } out_req_t;

  typedef struct packed {
    logic [1:0] count;
    out_req_t   lead;
    out_req_t   trail;
  } push_t;

  // Keyword text, first character in the low byte, zero padded.
  localparam logic [HEAD_W-1:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0074_6e69,
    64'h0000_0000_0000_6669,
    64'h0000_0000_0072_6f66,
    64'h0000_0065_6c69_6877,
    64'h0000_006b_6165_7262,
    64'h6575_6e69_746e_6f63,
    64'h0000_0000_6f74_7561,
    64'h0000_0000_6f74_6f67,
    64'h0000_6e72_7574_6572,
    64'h0000_0000_6469_6f76
  };

  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
    6'd3, 6'd2, 6'd3, 6'd5, 6'd5, 6'd8, 6'd4, 6'd4, 6'd6, 6'd4
  };

  function automatic logic kw_match(input logic [LEN_W-1:0] len,
                                    input logic [HEAD_W-1:0] head);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (len == KW_LEN[k] && head == KW_TEXT[k]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

FILE: rtl/core/ltc_core.sv
// Character decode, word state and token build for one request per cycle while accept is high.
module ltc_core
  import ltc_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  in_req_t char_req,
  output push_t   push
);

  typedef enum logic [2:0] {
    K_OTHER, K_HASH, K_SPACE, K_NEWLINE, K_SEP, K_OP, K_WORD
  } kind_t;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_WORD - 1);
  localparam logic [LEN_W-1:0] LEN_KEPT  = LEN_W'(KEPT_CHARS);

  logic [7:0]        head [KEPT_CHARS];
  logic [LEN_W-1:0]  len;
  logic              dir;
  logic [LEN_W-1:0]  len_next;
  logic              dir_next;

  kind_t             kind;
  logic              grow;
  logic              store;
  logic [LEN_W-1:0]  len_eff;
  logic [HEAD_W-1:0] head_eff;
  logic              ends_word;
  logic              word_fire;
  logic              char_fire;
  logic              directive;
  logic              eoi;
  out_req_t          word_tok;
  out_req_t          char_tok;

  assign eoi = char_req.end_of_input;

  always_comb begin
    unique case (char_req.char_code) inside
      CH_HASH:                 kind = K_HASH;
      CH_SPACE, CH_TAB:        kind = K_SPACE;
      CH_NEWLINE:              kind = K_NEWLINE;
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
      CH_COMMA, CH_COLON, CH_SEMICOLON:
                               kind = K_SEP;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_EQUAL:
                               kind = K_OP;
      [CH_DIGIT_0:CH_DIGIT_9], [CH_UPPER_A:CH_UPPER_Z],
      [CH_LOWER_A:CH_LOWER_Z], CH_UNDERSCORE:
                               kind = K_WORD;
      default:                 kind = K_OTHER;
    endcase
  end

  assign grow    = (kind == K_WORD) && (len < LEN_LIMIT);
  assign store   = grow && (len < LEN_KEPT);
  assign len_eff = grow ? len + LEN_W'(1) : len;

  always_comb begin
    head_eff = '0;
    for (int i = 0; i < KEPT_CHARS; i++) begin
      if (LEN_W'(i) < len_eff) begin
        head_eff[8*i +: 8] = (store && len == LEN_W'(i)) ? char_req.char_code : head[i];
      end
    end
  end

  assign ends_word = (kind == K_SPACE) || (kind == K_NEWLINE) ||
                     (kind == K_SEP) || (kind == K_OP);
  assign word_fire = (len_eff != '0) && (ends_word || eoi);
  assign char_fire = (kind == K_HASH) || (kind == K_SEP) || (kind == K_OP);
  assign directive = !((kind == K_SEP) || (kind == K_OP)) &&
                     (dir || (kind == K_HASH));

  always_comb begin
    word_tok.token_class  = directive ? CLS_PREPROC :
                            (kw_match(len_eff, head_eff) ? CLS_KEYWORD : CLS_IDENT);
    word_tok.token_length = len_eff;
    word_tok.token_head   = head_eff;
    word_tok.single_char  = '0;
    word_tok.last_of_run  = 1'b0;

    char_tok.token_class  = (kind == K_HASH) ? CLS_PREPROC :
                            ((kind == K_SEP) ? CLS_SEPARATOR : CLS_OPERATOR);
    char_tok.token_length = LEN_W'(1);
    char_tok.token_head   = '0;
    char_tok.single_char  = char_req.char_code;
    char_tok.last_of_run  = 1'b0;
  end

  always_comb begin
    push = '0;
    if (accept) begin
      if (word_fire && char_fire) begin
        push.count = 2'd2;
        if (kind == K_HASH) begin
          push.lead  = char_tok;
          push.trail = word_tok;
        end else begin
          push.lead  = word_tok;
          push.trail = char_tok;
        end
        push.trail.last_of_run = 1'b1;
      end else if (word_fire) begin
        push.count            = 2'd1;
        push.lead             = word_tok;
        push.lead.last_of_run = 1'b1;
      end else if (char_fire) begin
        push.count            = 2'd1;
        push.lead             = char_tok;
        push.lead.last_of_run = 1'b1;
      end
    end
  end

  always_comb begin
    len_next = len;
    dir_next = dir;
    if (accept) begin
      len_next = (word_fire || eoi) ? '0 : len_eff;
      if (eoi || kind == K_NEWLINE) begin
        dir_next = 1'b0;
      end else if (kind == K_HASH) begin
        dir_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      dir <= 1'b0;
    end else begin
      len <= len_next;
      dir <= dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      head[len[HEAD_IDX_W-1:0]] <= char_req.char_code;
    end
  end

endmodule

FILE: rtl/core/ltc_queue.sv
// Result queue: takes up to two tokens a cycle, hands out one unless tok_stall is high.
module ltc_queue
  import ltc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  push_t    push,
  output logic     room,
  output logic     tok_valid,
  input  logic     tok_stall,
  output out_req_t tok_req
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(QUEUE_DEPTH - 2);

  out_req_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign tok_valid = (count != '0);
  assign tok_req   = slots[rd_ptr];
  assign pop       = tok_valid && !tok_stall;
  assign room      = (count <= ROOM_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.lead;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + PTR_W'(1)] <= push.trail;
    end
  end

endmodule

FILE: rtl/core/lexical_token_classifier.sv
// Top level of the lexical token classifier.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+---------------------
//   char    | char_valid | char_stall | char_req (in_req_t)
//   tok     | tok_valid  | tok_stall  | tok_req  (out_req_t)
//
// One character is taken per cycle while char_stall is low; its tokens enter
// the result queue at the edge that accepts it and leave one per cycle while
// tok_stall is low, from the next edge on; a word-ending token character gives two.
// The four-entry result queue sets char_stall: it rises when fewer than
// two entries are free and does not look at char_valid.
// Reset clears the word length, the directive flag and the queue.
module lexical_token_classifier
  import ltc_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_stall,
  input  in_req_t  char_req,
  output logic     tok_valid,
  input  logic     tok_stall,
  output out_req_t tok_req
);

  logic  char_accept;
  logic  room;
  push_t push;

  assign char_stall  = !room;
  assign char_accept = char_valid && !char_stall;

  ltc_core #(
    .MAX_WORD (MAX_WORD)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (char_accept),
    .char_req (char_req),
    .push     (push)
  );

  ltc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_req   (tok_req)
  );

`ifndef SYNTHESIS
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    !char_accept |-> push.count == 2'd0)
    else $error("tokens pushed without an accepted request");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |=> tok_valid)
    else $error("pushed tokens not visible at output");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd1 |-> push.lead.last_of_run)
    else $error("single token not marked last");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.trail.last_of_run && !push.lead.last_of_run)
    else $error("token pair marked wrong");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("more than two tokens from one request");
`endif

endmodule
